@@ design/kpn_pkg.sv @@
// Shared types, widths and codes of the keyframe pose blender.
package kpn_pkg;

   localparam int RATE_W      = 10;
   localparam int KCNT_W      = 6;
   localparam int KEY_W       = 5;
   localparam int JOINT_W     = 6;
   localparam int FRAME_W     = 10;
   localparam int POS_W       = 32;
   localparam int QUAT_W      = 16;
   localparam int MAT_W       = 16;
   localparam int IDX_W       = 8;
   localparam int T_W         = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYBACK_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT     = 2'd1;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   localparam logic [RATE_W-1:0] RATE_RESET = 10'd120;
   localparam logic [KCNT_W-1:0] KCNT_RESET = 6'd1;
   localparam logic [T_W-1:0]    ONE_T      = 17'd65536;
   localparam int                ONE_Q      = 16384;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [QUAT_W-1:0] quat_type;
   typedef logic signed [MAT_W-1:0]  mat_type;

   typedef struct packed {
      pos_type x;
      pos_type y;
      pos_type z;
   } vec_type;

   typedef struct packed {
      quat_type w;
      quat_type x;
      quat_type y;
      quat_type z;
   } rot_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [KCNT_W-1:0] kcnt;
   } cfg_type;

   typedef struct packed {
      logic               is_eval;
      logic               wr_en;
      logic               joint_ok;
      logic [JOINT_W-1:0] joint;
      logic [IDX_W-1:0]   key_a;
      logic [IDX_W-1:0]   key_b;
      logic [T_W-1:0]     t;
      vec_type            pos;
      rot_type            rot;
   } job_type;

   function automatic mat_type sat16(input logic signed [19:0] v);
      mat_type r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[MAT_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/kpn_ifs.sv @@
// Handshake channels of the keyframe pose blender.
interface kpn_req_if;
   import kpn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [KEY_W-1:0]     key_slot;
   logic [JOINT_W-1:0]   joint_slot;
   pos_type              pos_x;
   pos_type              pos_y;
   pos_type              pos_z;
   quat_type             quat_w;
   quat_type             quat_x;
   quat_type             quat_y;
   quat_type             quat_z;
   logic [FRAME_W-1:0]   play_frame;
   modport source (output valid, req_type, key_slot, joint_slot, pos_x, pos_y, pos_z,
                   quat_w, quat_x, quat_y, quat_z, play_frame, input ready);
   modport sink (input valid, req_type, key_slot, joint_slot, pos_x, pos_y, pos_z,
                 quat_w, quat_x, quat_y, quat_z, play_frame, output ready);
endinterface

interface kpn_rsp_if;
   import kpn_pkg::*;
   logic    valid;
   logic    ready;
   mat_type m00;
   mat_type m01;
   mat_type m02;
   mat_type m10;
   mat_type m11;
   mat_type m12;
   mat_type m20;
   mat_type m21;
   mat_type m22;
   pos_type out_tx;
   pos_type out_ty;
   pos_type out_tz;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   out_tx, out_ty, out_tz, input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 out_tx, out_ty, out_tz, output ready);
endinterface

interface kpn_csr_if;
   import kpn_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/kpn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module kpn_div #(
   parameter int DW = 28,
   parameter int VW = 11,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [QW-1:0] quotient
);
   localparam int SW = (DW > VW + QW) ? DW : VW + QW;

   logic [SW-1:0] rem_ff [QW];
   logic [SW-1:0] rem_in [QW];
   logic [VW-1:0] dvs_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [QW-1:0] quo_in [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [SW-1:0] rem_src;
      logic [SW-1:0] shifted;
      logic [VW-1:0] dvs_src;
      logic [QW-1:0] quo_src;
      if (i == 0) begin : g_first
         assign rem_src = SW'(dividend);
         assign dvs_src = divisor;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign dvs_src = dvs_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end
      assign shifted = SW'(dvs_src) << (QW - 1 - i);
      always_comb begin
         if (rem_src >= shifted) begin
            rem_in[i] = rem_src - shifted;
            quo_in[i] = quo_src | (QW'(1) << (QW - 1 - i));
         end else begin
            rem_in[i] = rem_src;
            quo_in[i] = quo_src;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            dvs_ff[i] <= dvs_src;
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

@@ design/kpn_front.sv @@
// Front end: accepts requests, finds the key segment and the blend weight.
module kpn_front import kpn_pkg::*; #(
   parameter int MAX_KEYS   = 32,
   parameter int MAX_JOINTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   kpn_req_if.sink req_ch,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int PROD_W = FRAME_W + CNT_W;
   localparam int DVD_W  = RATE_W + T_W + 1;
   localparam int DVS_W  = RATE_W + 1;
   localparam int LAT    = T_W;

   logic [RATE_W-1:0] rate;
   logic [CNT_W-1:0]  kc;
   logic              adv;

   logic              v0_ff;
   job_type           j0_ff, j0_in;
   logic [PROD_W-1:0] prod0_ff, prod0_in;

   logic                v1_ff;
   job_type             j1_ff;
   logic [PROD_W-1:0]   prod1_ff;
   logic [MAX_KEYS-1:0] th1_ff, th1_in;

   logic             v2_ff;
   job_type          j2_ff, j2_in;
   logic [DVD_W-1:0] dvd2_ff, dvd2_in;

   logic           vd_ff [LAT];
   job_type        jd_ff [LAT];
   logic [T_W-1:0] t_q;

   always_comb begin
      rate = (cfg.rate == '0) ? RATE_W'(1) : cfg.rate;
      if (cfg.kcnt == '0) begin
         kc = CNT_W'(1);
      end else if (int'(cfg.kcnt) > MAX_KEYS) begin
         kc = CNT_W'(MAX_KEYS);
      end else begin
         kc = CNT_W'(cfg.kcnt);
      end
   end

   assign adv          = !vd_ff[LAT-1] || job_ready;
   assign req_ch.ready = adv;

   always_comb begin
      j0_in          = '0;
      j0_in.is_eval  = (req_ch.req_type == REQ_EVAL);
      j0_in.joint_ok = (int'(req_ch.joint_slot) < MAX_JOINTS);
      j0_in.wr_en    = (req_ch.req_type == REQ_WRITE) && (int'(req_ch.key_slot) < MAX_KEYS)
                       && (int'(req_ch.joint_slot) < MAX_JOINTS);
      j0_in.joint    = req_ch.joint_slot;
      j0_in.key_a    = IDX_W'(req_ch.key_slot);
      j0_in.pos      = '{x: req_ch.pos_x, y: req_ch.pos_y, z: req_ch.pos_z};
      j0_in.rot      = '{w: req_ch.quat_w, x: req_ch.quat_x, y: req_ch.quat_y,
                         z: req_ch.quat_z};
      prod0_in       = PROD_W'(req_ch.play_frame) * PROD_W'(kc);
   end

   always_comb begin
      for (int j = 1; j <= MAX_KEYS; j++) begin
         th1_in[j-1] = (j <= int'(kc)) && (j * int'(rate) < int'(prod0_ff));
      end
   end

   always_comb begin
      int cnt;
      int c;
      int base;
      int num;
      int ib;
      cnt = $countones(th1_ff);
      if (cnt == int'(kc)) begin
         c    = 0;
         base = 0;
      end else begin
         c    = cnt;
         base = int'(prod1_ff);
      end
      num = (c + 1) * int'(rate) - base;
      ib  = (c >= int'(kc) - 1) ? 0 : c + 1;
      j2_in = j1_ff;
      if (j1_ff.is_eval) begin
         j2_in.key_a = IDX_W'(c);
         j2_in.key_b = IDX_W'(ib);
      end
      dvd2_in = (DVD_W'(num) << T_W) + DVD_W'(rate);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int i = 0; i < LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v0_ff    <= req_ch.valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int i = 1; i < LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         j0_ff    <= j0_in;
         prod0_ff <= prod0_in;
         j1_ff    <= j0_ff;
         prod1_ff <= prod0_ff;
         th1_ff   <= th1_in;
         j2_ff    <= j2_in;
         dvd2_ff  <= dvd2_in;
         jd_ff[0] <= j2_ff;
         for (int i = 1; i < LAT; i++) begin
            jd_ff[i] <= jd_ff[i-1];
         end
      end
   end

   kpn_div #(.DW(DVD_W), .VW(DVS_W), .QW(T_W)) u_tdiv (
      .clock    (clock),
      .adv      (adv),
      .dividend (dvd2_ff),
      .divisor  (DVS_W'(rate) << 1),
      .quotient (t_q)
   );

   assign job_valid = vd_ff[LAT-1];

   always_comb begin
      job   = jd_ff[LAT-1];
      job.t = t_q;
   end

endmodule

@@ design/kpn_queue.sv @@
// Small job queue between the front and back ends.
module kpn_queue import kpn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slots [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slots[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[tail_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not grow on push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count did not shrink on pop");
`endif

endmodule

@@ design/kpn_back.sv @@
// Back end: pose store, blend, normalize and matrix build.
module kpn_back import kpn_pkg::*; #(
   parameter int MAX_KEYS   = 32,
   parameter int MAX_JOINTS = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   output logic     job_ready,
   input  job_type  job,
   kpn_rsp_if.source rsp_ch
);
   localparam int DEPTH = MAX_KEYS * MAX_JOINTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PT_W  = T_W + 1 + POS_W;
   localparam int PQ_W  = T_W + 1 + QUAT_W;
   localparam int SQ_W  = 2 * QUAT_W;
   localparam int N_W   = SQ_W + 1;
   localparam int V_W   = SQ_W + 2;
   localparam int D_W   = V_W + 17;
   localparam int E_W   = N_W + 1;
   localparam int Q_W   = 17;
   localparam int LAT   = Q_W;

   localparam int P_WW = 0;
   localparam int P_XX = 1;
   localparam int P_YY = 2;
   localparam int P_ZZ = 3;
   localparam int P_XY = 4;
   localparam int P_XZ = 5;
   localparam int P_YZ = 6;
   localparam int P_WX = 7;
   localparam int P_WY = 8;
   localparam int P_WZ = 9;

   vec_type key_translations [DEPTH];
   rot_type key_rotations [DEPTH];

   logic          adv;
   logic          take;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;

   logic           v1_ff;
   logic [T_W-1:0] t1_ff;
   logic           jok1_ff;
   vec_type        ta1_ff, tb1_ff;
   rot_type        qa1_ff, qb1_ff;

   logic                   v2_ff;
   logic signed [PT_W-1:0] pta2_ff [3], pta2_in [3];
   logic signed [PT_W-1:0] ptb2_ff [3], ptb2_in [3];
   logic signed [PQ_W-1:0] pqa2_ff [4], pqa2_in [4];
   logic signed [PQ_W-1:0] pqb2_ff [4], pqb2_in [4];

   logic     v3_ff;
   pos_type  tr3_ff [3], tr3_in [3];
   quat_type q3_ff [4], q3_in [4];

   logic                   v4_ff;
   pos_type                tr4_ff [3];
   logic signed [SQ_W-1:0] pr4_ff [10], pr4_in [10];

   logic                  v5_ff;
   pos_type               tr5_ff [3];
   logic [N_W-1:0]        n5_ff, n5_in;
   logic signed [V_W-1:0] v5v_ff [9], v5v_in [9];

   logic           v6_ff;
   pos_type        tr6_ff [3];
   logic           nz6_ff;
   logic [8:0]     neg6_ff, neg6_in;
   logic [D_W-1:0] u6_ff [9], u6_in [9];
   logic [E_W-1:0] e6_ff;

   logic           vd_ff [LAT];
   logic           nzd_ff [LAT];
   logic [8:0]     negd_ff [LAT];
   vec_type        trd_ff [LAT];
   logic [Q_W-1:0] quo [9];

   logic    out_v_ff;
   mat_type m_ff [9], m_in [9];
   pos_type tro_ff [3];

   assign adv       = !out_v_ff || rsp_ch.ready;
   assign job_ready = adv;
   assign take      = job_valid && adv;
   assign addr_a    = AW'(int'(job.key_a) * MAX_JOINTS + int'(job.joint));
   assign addr_b    = AW'(int'(job.key_b) * MAX_JOINTS + int'(job.joint));

   always_ff @(posedge clock) begin
      if (take && !job.is_eval && job.wr_en) begin
         key_translations[addr_a] <= job.pos;
         key_rotations[addr_a]    <= job.rot;
      end
      if (adv) begin
         ta1_ff <= key_translations[addr_a];
         tb1_ff <= key_translations[addr_b];
         qa1_ff <= key_rotations[addr_a];
         qb1_ff <= key_rotations[addr_b];
      end
   end

   always_comb begin
      vec_type ta;
      vec_type tb;
      rot_type qa;
      rot_type qb;
      logic signed [T_W:0] wa;
      logic signed [T_W:0] wb;
      ta = jok1_ff ? ta1_ff : '0;
      tb = jok1_ff ? tb1_ff : '0;
      qa = jok1_ff ? qa1_ff : '0;
      qb = jok1_ff ? qb1_ff : '0;
      wa = signed'({1'b0, t1_ff});
      wb = signed'({1'b0, ONE_T - t1_ff});
      pta2_in[0] = PT_W'(wa) * PT_W'(ta.x);
      pta2_in[1] = PT_W'(wa) * PT_W'(ta.y);
      pta2_in[2] = PT_W'(wa) * PT_W'(ta.z);
      ptb2_in[0] = PT_W'(wb) * PT_W'(tb.x);
      ptb2_in[1] = PT_W'(wb) * PT_W'(tb.y);
      ptb2_in[2] = PT_W'(wb) * PT_W'(tb.z);
      pqa2_in[0] = PQ_W'(wa) * PQ_W'(qa.w);
      pqa2_in[1] = PQ_W'(wa) * PQ_W'(qa.x);
      pqa2_in[2] = PQ_W'(wa) * PQ_W'(qa.y);
      pqa2_in[3] = PQ_W'(wa) * PQ_W'(qa.z);
      pqb2_in[0] = PQ_W'(wb) * PQ_W'(qb.w);
      pqb2_in[1] = PQ_W'(wb) * PQ_W'(qb.x);
      pqb2_in[2] = PQ_W'(wb) * PQ_W'(qb.y);
      pqb2_in[3] = PQ_W'(wb) * PQ_W'(qb.z);
   end

   always_comb begin
      logic signed [PT_W:0] st;
      logic signed [PQ_W:0] sq;
      for (int i = 0; i < 3; i++) begin
         st = (PT_W + 1)'(pta2_ff[i]) + (PT_W + 1)'(ptb2_ff[i]) + (PT_W + 1)'(32768);
         tr3_in[i] = st[POS_W+15:16];
      end
      for (int i = 0; i < 4; i++) begin
         sq = (PQ_W + 1)'(pqa2_ff[i]) + (PQ_W + 1)'(pqb2_ff[i]) + (PQ_W + 1)'(32768);
         q3_in[i] = sq[QUAT_W+15:16];
      end
   end

   always_comb begin
      pr4_in[P_WW] = q3_ff[0] * q3_ff[0];
      pr4_in[P_XX] = q3_ff[1] * q3_ff[1];
      pr4_in[P_YY] = q3_ff[2] * q3_ff[2];
      pr4_in[P_ZZ] = q3_ff[3] * q3_ff[3];
      pr4_in[P_XY] = q3_ff[1] * q3_ff[2];
      pr4_in[P_XZ] = q3_ff[1] * q3_ff[3];
      pr4_in[P_YZ] = q3_ff[2] * q3_ff[3];
      pr4_in[P_WX] = q3_ff[0] * q3_ff[1];
      pr4_in[P_WY] = q3_ff[0] * q3_ff[2];
      pr4_in[P_WZ] = q3_ff[0] * q3_ff[3];
   end

   always_comb begin
      logic signed [V_W-1:0] p [10];
      for (int i = 0; i < 10; i++) begin
         p[i] = V_W'(pr4_ff[i]);
      end
      n5_in     = N_W'(p[P_WW] + p[P_XX] + p[P_YY] + p[P_ZZ]);
      v5v_in[0] = p[P_YY] + p[P_ZZ];
      v5v_in[1] = p[P_XY] - p[P_WZ];
      v5v_in[2] = p[P_XZ] + p[P_WY];
      v5v_in[3] = p[P_XY] + p[P_WZ];
      v5v_in[4] = p[P_XX] + p[P_ZZ];
      v5v_in[5] = p[P_YZ] - p[P_WX];
      v5v_in[6] = p[P_XZ] - p[P_WY];
      v5v_in[7] = p[P_YZ] + p[P_WX];
      v5v_in[8] = p[P_XX] + p[P_YY];
   end

   always_comb begin
      logic signed [D_W:0] d;
      logic signed [D_W:0] e;
      e = signed'((D_W + 1)'({n5_ff, 1'b0}));
      for (int i = 0; i < 9; i++) begin
         d = ((D_W + 1)'(v5v_ff[i]) <<< 16) + signed'((D_W + 1)'(n5_ff));
         neg6_in[i] = d[D_W];
         if (d[D_W]) begin
            u6_in[i] = D_W'(e - d - (D_W + 1)'(1));
         end else begin
            u6_in[i] = D_W'(d);
         end
      end
   end

   for (genvar g = 0; g < 9; g++) begin : g_div
      kpn_div #(.DW(D_W), .VW(E_W), .QW(Q_W)) u_div (
         .clock    (clock),
         .adv      (adv),
         .dividend (u6_ff[g]),
         .divisor  (e6_ff),
         .quotient (quo[g])
      );
   end

   always_comb begin
      logic signed [19:0] qs;
      for (int i = 0; i < 9; i++) begin
         qs = signed'(20'(quo[i]));
         if (negd_ff[LAT-1][i]) begin
            qs = -qs;
         end
         if (i == 0 || i == 4 || i == 8) begin
            qs = 20'sd16384 - qs;
         end
         if (nzd_ff[LAT-1]) begin
            m_in[i] = (i == 0 || i == 4 || i == 8) ? MAT_W'(ONE_Q) : '0;
         end else begin
            m_in[i] = sat16(qs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= take && job.is_eval;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vd_ff[0] <= v6_ff;
         for (int i = 1; i < LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         out_v_ff <= vd_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= job.t;
         jok1_ff <= job.joint_ok;
         pta2_ff <= pta2_in;
         ptb2_ff <= ptb2_in;
         pqa2_ff <= pqa2_in;
         pqb2_ff <= pqb2_in;
         tr3_ff  <= tr3_in;
         q3_ff   <= q3_in;
         tr4_ff  <= tr3_ff;
         pr4_ff  <= pr4_in;
         tr5_ff  <= tr4_ff;
         n5_ff   <= n5_in;
         v5v_ff  <= v5v_in;
         tr6_ff  <= tr5_ff;
         nz6_ff  <= (n5_ff == '0);
         neg6_ff <= neg6_in;
         u6_ff   <= u6_in;
         e6_ff   <= {n5_ff, 1'b0};
         nzd_ff[0]  <= nz6_ff;
         negd_ff[0] <= neg6_ff;
         trd_ff[0]  <= '{x: tr6_ff[0], y: tr6_ff[1], z: tr6_ff[2]};
         for (int i = 1; i < LAT; i++) begin
            nzd_ff[i]  <= nzd_ff[i-1];
            negd_ff[i] <= negd_ff[i-1];
            trd_ff[i]  <= trd_ff[i-1];
         end
         m_ff      <= m_in;
         tro_ff[0] <= trd_ff[LAT-1].x;
         tro_ff[1] <= trd_ff[LAT-1].y;
         tro_ff[2] <= trd_ff[LAT-1].z;
      end
   end

   assign rsp_ch.valid  = out_v_ff;
   assign rsp_ch.m00    = m_ff[0];
   assign rsp_ch.m01    = m_ff[1];
   assign rsp_ch.m02    = m_ff[2];
   assign rsp_ch.m10    = m_ff[3];
   assign rsp_ch.m11    = m_ff[4];
   assign rsp_ch.m12    = m_ff[5];
   assign rsp_ch.m20    = m_ff[6];
   assign rsp_ch.m21    = m_ff[7];
   assign rsp_ch.m22    = m_ff[8];
   assign rsp_ch.out_tx = tro_ff[0];
   assign rsp_ch.out_ty = tro_ff[1];
   assign rsp_ch.out_tz = tro_ff[2];

endmodule

@@ design/keyframe_pose_nlerp_to_matrix.sv @@
// Keyframe pose blender: stores per-joint keyframe poses and returns the nlerp-blended
// 3x4 pose matrix of a joint at a playback frame. One request is taken per clock unless the
// queue stalls the front end. A pose write lands in the store when the back end takes it and
// affects every later evaluate; an evaluate passes through the 17-stage weight divider in the
// front end and the 17-stage normalizing dividers in the back end. A four-entry queue sits
// between the two ends. The pose store has no reset and needs no clearing pass.
// Configuration writes are taken every cycle.
module keyframe_pose_nlerp_to_matrix import kpn_pkg::*; #(
   parameter int MAX_KEYS   = 32,
   parameter int MAX_JOINTS = 64
) (
   input  logic      clock,
   input  logic      reset,
   kpn_csr_if.sink   csr_ch,
   kpn_req_if.sink   req_ch,
   kpn_rsp_if.source rsp_ch
);

   logic [RATE_W-1:0] rate_ff;
   logic [KCNT_W-1:0] kcnt_ff;
   cfg_type           cfg;

   logic    fj_valid;
   logic    fj_ready;
   job_type fj;
   logic    bj_valid;
   logic    bj_ready;
   job_type bj;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         kcnt_ff <= KCNT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PLAYBACK_RATE: begin
               rate_ff <= csr_ch.data[RATE_W-1:0];
            end
            CSR_KEY_COUNT: begin
               kcnt_ff <= csr_ch.data[KCNT_W-1:0];
            end
            default: begin
               rate_ff <= rate_ff;
            end
         endcase
      end
   end

   assign cfg = '{rate: rate_ff, kcnt: kcnt_ff};

   kpn_front #(.MAX_KEYS(MAX_KEYS), .MAX_JOINTS(MAX_JOINTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .job_valid (fj_valid),
      .job_ready (fj_ready),
      .job       (fj)
   );

   kpn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_data  (fj),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_data   (bj)
   );

   kpn_back #(.MAX_KEYS(MAX_KEYS), .MAX_JOINTS(MAX_JOINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bj_valid),
      .job_ready (bj_ready),
      .job       (bj),
      .rsp_ch    (rsp_ch)
   );

endmodule
